// ----- hdl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, constants and size-class tables of the binned slab allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

	// arena geometry
	localparam int NUM_PAGES    = 64;
	localparam int PAGE_W       = 6;
	localparam int PTR_W        = PAGE_W + 1;
	localparam logic [PTR_W-1:0] NO_PAGE = PTR_W'(NUM_PAGES);
	localparam int NUM_BINS     = 51;
	localparam int BIN_W        = 6;
	localparam int MAX_SLOTS    = 4096;
	localparam int POS_W        = 12;
	localparam int CNT_W        = 13;
	localparam int HEADER_BYTES = 48;
	localparam int MAX_SMALL    = 32768 - 16;
	localparam int SIZE_W       = 16;
	localparam int OFF_W        = 16;
	localparam int ADDR_W       = 22;
	localparam int STK_AW       = PAGE_W + POS_W;
	localparam int STK_DEPTH    = NUM_PAGES * MAX_SLOTS;

	// commands
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NO_PAGE  = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE = 2'd2;
	localparam logic [1:0] ST_BAD_FREE = 2'd3;

	// slot size of each class
	localparam logic [SIZE_W-1:0] BIN_SIZE [NUM_BINS] = '{
		16'd16, 16'd32, 16'd48, 16'd64, 16'd80, 16'd96, 16'd112, 16'd128, 16'd144,
		16'd160, 16'd176, 16'd192, 16'd208, 16'd256, 16'd288, 16'd320, 16'd384,
		16'd448, 16'd512, 16'd560, 16'd624, 16'd720, 16'd816, 16'd912, 16'd1008,
		16'd1168, 16'd1392, 16'd1520, 16'd1680, 16'd1872, 16'd2032, 16'd2256,
		16'd2608, 16'd2976, 16'd3264, 16'd3632, 16'd4080, 16'd4368, 16'd4672,
		16'd5040, 16'd5456, 16'd5952, 16'd6544, 16'd7280, 16'd8176, 16'd9360,
		16'd10912, 16'd13104, 16'd16368, 16'd21840, 16'd32752
	};

	// slots per page of each class: (page bytes - header) / slot size
	localparam logic [CNT_W-1:0] CAPACITY [NUM_BINS] = '{
		13'd4093, 13'd2046, 13'd1364, 13'd1023, 13'd818, 13'd682, 13'd584, 13'd511,
		13'd454, 13'd409, 13'd372, 13'd341, 13'd314, 13'd255, 13'd227, 13'd204,
		13'd170, 13'd146, 13'd127, 13'd116, 13'd104, 13'd90, 13'd80, 13'd71,
		13'd64, 13'd56, 13'd47, 13'd43, 13'd38, 13'd34, 13'd32, 13'd29, 13'd25,
		13'd22, 13'd20, 13'd18, 13'd16, 13'd14, 13'd14, 13'd12, 13'd12, 13'd11,
		13'd10, 13'd8, 13'd8, 13'd6, 13'd6, 13'd4, 13'd4, 13'd2, 13'd1
	};

	// per-page record
	typedef struct packed {
		logic [BIN_W-1:0] cls;
		logic [CNT_W-1:0] free;
		logic [CNT_W-1:0] low;
		logic [PTR_W-1:0] nxt;
		logic [PTR_W-1:0] prv;
		logic             on;
	} prec_t;

	localparam int REC_W = $bits(prec_t);

	// memory requests
	typedef struct packed {
		logic              re;
		logic              we;
		logic [PAGE_W-1:0] addr;
		prec_t             mask;
		prec_t             wdata;
	} rec_req_t;

	typedef struct packed {
		logic             re;
		logic             we;
		logic [BIN_W-1:0] addr;
		logic [PTR_W-1:0] wdata;
	} lh_req_t;

	typedef struct packed {
		logic              re;
		logic              we;
		logic [STK_AW-1:0] addr;
		logic [OFF_W-1:0]  wdata;
	} stk_req_t;

	// one result item
	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block_address;
		logic [BIN_W-1:0]  bin;
		logic              page_created;
		logic              page_released;
	} result_t;

	// smallest class whose slot size is not below the rounded size
	function automatic logic [BIN_W-1:0] size_to_bin(input logic [SIZE_W:0] rounded);
		logic [BIN_W-1:0] n;
		n = '0;
		for (int b = 0; b < NUM_BINS; b++) begin
			if ({1'b0, BIN_SIZE[b]} < rounded) begin
				n = n + BIN_W'(1);
			end
		end
		if (n > BIN_W'(NUM_BINS - 1)) begin
			n = BIN_W'(NUM_BINS - 1);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/bsa_ram.sv -----
// ----------------------------------------------------------------------------
// bsa_ram
// Single-port synchronous RAM with bit write mask and registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic          clk,
	input  wire logic          re,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wmask,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// masked write, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= (mem[addr] & ~wmask) | (wdata & wmask);
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hdl/bsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: reads, modifies and writes back page records, list heads
// and slot stacks for one allocate or free item at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      command,
	input  wire logic [15:0]               size,
	input  wire logic [21:0]               address,
	output logic                           res_valid,
	input  wire logic                      res_ready,
	output bsa_pkg::result_t               res,
	output bsa_pkg::rec_req_t              rec_req,
	input  wire bsa_pkg::prec_t            rec_rdata,
	output bsa_pkg::lh_req_t               lh_req,
	input  wire logic [bsa_pkg::PTR_W-1:0] lh_rdata,
	output bsa_pkg::stk_req_t              stk_req,
	input  wire logic [bsa_pkg::OFF_W-1:0] stk_rdata
);

	import bsa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_DEC, S_A_HEAD, S_A_REC, S_A_OFF, S_F_REC,
		S_L1, S_L2, S_U1, S_U2, S_U3, S_DONE
	} state_t;

	state_t                state_q;
	logic [NUM_PAGES-1:0]  used_q;
	logic [NUM_BINS-1:0]   lh_vld_q;
	logic                  lh_rd_vld_q;

	logic                  cmd_q;
	logic [SIZE_W-1:0]     size_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [BIN_W-1:0]      b_q;
	logic [PAGE_W-1:0]     p_q;
	logic [POS_W-1:0]      pos_q;
	logic                  calc_q;
	logic                  unl_q;
	logic [PTR_W-1:0]      pv_q;
	logic [PTR_W-1:0]      nx_q;
	logic [OFF_W-1:0]      off_q;
	logic [1:0]            st_q;
	logic                  created_q;
	logic                  released_q;
	logic [PTR_W-1:0]      ffree_q;

	logic [PTR_W-1:0]      head;
	logic [SIZE_W:0]       rounded;
	logic                  size_bad;
	logic [BIN_W-1:0]      dec_bin;
	logic [PAGE_W-1:0]     free_pg;
	logic [CNT_W-1:0]      a_pos;
	logic                  a_calc;
	logic [BIN_W-1:0]      f_bin;
	logic [CNT_W-1:0]      f_new;
	logic                  f_rel;
	logic [CNT_W-1:0]      fresh_pos;
	logic [PTR_W-1:0]      ffree;
	logic [27:0]           prod;
	logic [OFF_W-1:0]      off_calc;
	logic                  fresh_go;

	// decode helpers
	assign head      = lh_rd_vld_q ? lh_rdata : NO_PAGE;
	assign rounded   = ({1'b0, size_q} + (SIZE_W+1)'(15)) & ~(SIZE_W+1)'(15);
	assign size_bad  = (size_q == '0) || (size_q > SIZE_W'(MAX_SMALL));
	assign dec_bin   = size_to_bin(rounded);
	assign free_pg   = addr_q[ADDR_W-1 -: PAGE_W];
	assign a_pos     = (rec_rdata.free == '0) ? '0 : rec_rdata.free - CNT_W'(1);
	assign a_calc    = a_pos < rec_rdata.low;
	assign f_bin     = (rec_rdata.cls >= BIN_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
	                                                       : rec_rdata.cls;
	assign f_new     = rec_rdata.free + CNT_W'(1);
	assign f_rel     = f_new >= CAPACITY[f_bin];
	assign fresh_pos = CAPACITY[b_q] - CNT_W'(1);
	assign fresh_go  = head[PTR_W-1] && !ffree_q[PTR_W-1];

	// lowest free page
	always_comb begin
		ffree = NO_PAGE;
		for (int i = NUM_PAGES - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				ffree = {1'b0, PAGE_W'(i)};
			end
		end
	end

	// slot offset for a never-written stack position
	assign prod     = 28'(pos_q) * 28'(BIN_SIZE[b_q]);
	assign off_calc = prod[OFF_W-1:0] + OFF_W'(HEADER_BYTES);

	// memory requests
	always_comb begin
		rec_req = '0;
		lh_req  = '0;
		stk_req = '0;
		case (state_q)
			S_DEC: begin
				if (cmd_q == CMD_FREE) begin
					rec_req.re   = used_q[free_pg];
					rec_req.addr = free_pg;
				end else begin
					lh_req.re   = !size_bad;
					lh_req.addr = dec_bin;
				end
			end
			S_A_HEAD: begin
				if (fresh_go) begin
					rec_req.we          = 1'b1;
					rec_req.addr        = ffree_q[PAGE_W-1:0];
					rec_req.mask        = '1;
					rec_req.wdata.cls   = b_q;
					rec_req.wdata.free  = fresh_pos;
					rec_req.wdata.low   = fresh_pos;
					rec_req.wdata.nxt   = NO_PAGE;
					rec_req.wdata.prv   = NO_PAGE;
					rec_req.wdata.on    = fresh_pos != '0;
					lh_req.we           = 1'b1;
					lh_req.addr         = b_q;
					lh_req.wdata        = (fresh_pos != '0) ? ffree_q : NO_PAGE;
				end else if (!head[PTR_W-1]) begin
					rec_req.re   = 1'b1;
					rec_req.addr = head[PAGE_W-1:0];
				end
			end
			S_A_REC: begin
				rec_req.we         = 1'b1;
				rec_req.addr       = p_q;
				rec_req.mask.free  = '1;
				rec_req.mask.low   = '1;
				rec_req.wdata.free = a_pos;
				rec_req.wdata.low  = a_calc ? a_pos : rec_rdata.low;
				stk_req.re         = !a_calc;
				stk_req.addr       = {p_q, a_pos[POS_W-1:0]};
			end
			S_F_REC: begin
				stk_req.we         = 1'b1;
				stk_req.addr       = {p_q, rec_rdata.free[POS_W-1:0]};
				stk_req.wdata      = addr_q[OFF_W-1:0];
				rec_req.we         = 1'b1;
				rec_req.addr       = p_q;
				rec_req.mask.free  = '1;
				rec_req.wdata.free = f_new;
				lh_req.re          = 1'b1;
				lh_req.addr        = f_bin;
			end
			S_L1: begin
				rec_req.we        = !head[PTR_W-1];
				rec_req.addr      = head[PAGE_W-1:0];
				rec_req.mask.prv  = '1;
				rec_req.wdata.prv = {1'b0, p_q};
			end
			S_L2: begin
				lh_req.we         = 1'b1;
				lh_req.addr       = b_q;
				lh_req.wdata      = {1'b0, p_q};
				rec_req.we        = 1'b1;
				rec_req.addr      = p_q;
				rec_req.mask.nxt  = '1;
				rec_req.mask.prv  = '1;
				rec_req.mask.on   = 1'b1;
				rec_req.wdata.nxt = nx_q;
				rec_req.wdata.prv = NO_PAGE;
				rec_req.wdata.on  = 1'b1;
			end
			S_U1: begin
				if (!pv_q[PTR_W-1]) begin
					rec_req.we        = 1'b1;
					rec_req.addr      = pv_q[PAGE_W-1:0];
					rec_req.mask.nxt  = '1;
					rec_req.wdata.nxt = nx_q;
				end else begin
					lh_req.we    = 1'b1;
					lh_req.addr  = b_q;
					lh_req.wdata = nx_q;
				end
			end
			S_U2: begin
				rec_req.we        = !nx_q[PTR_W-1];
				rec_req.addr      = nx_q[PAGE_W-1:0];
				rec_req.mask.prv  = '1;
				rec_req.wdata.prv = pv_q;
			end
			S_U3: begin
				rec_req.we        = 1'b1;
				rec_req.addr      = p_q;
				rec_req.mask.nxt  = '1;
				rec_req.mask.prv  = '1;
				rec_req.mask.on   = 1'b1;
				rec_req.wdata.nxt = NO_PAGE;
				rec_req.wdata.prv = NO_PAGE;
				rec_req.wdata.on  = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// sequencer state, page-use bits and list-head valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			lh_vld_q    <= '0;
			lh_rd_vld_q <= 1'b0;
		end else begin
			if (lh_req.re) begin
				lh_rd_vld_q <= lh_vld_q[lh_req.addr];
			end
			if (lh_req.we) begin
				lh_vld_q[lh_req.addr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (cmd_q == CMD_ALLOC) begin
						state_q <= size_bad ? S_DONE : S_A_HEAD;
					end else begin
						state_q <= used_q[free_pg] ? S_F_REC : S_DONE;
					end
				end
				S_A_HEAD: begin
					if (fresh_go) begin
						used_q[ffree_q[PAGE_W-1:0]] <= 1'b1;
						state_q <= S_A_OFF;
					end else if (head[PTR_W-1]) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_A_REC;
					end
				end
				S_A_REC: state_q <= S_A_OFF;
				S_A_OFF: state_q <= unl_q ? S_U1 : S_DONE;
				S_F_REC: begin
					if (f_rel) begin
						used_q[p_q] <= 1'b0;
						state_q <= rec_rdata.on ? S_U1 : S_DONE;
					end else if (rec_rdata.free == '0 && !rec_rdata.on) begin
						state_q <= S_L1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_DONE;
				S_U1: state_q <= S_U2;
				S_U2: state_q <= S_U3;
				S_U3: state_q <= S_DONE;
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload and working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q  <= command;
					size_q <= size;
					addr_q <= address;
				end
			end
			S_DEC: begin
				st_q       <= ST_OK;
				created_q  <= 1'b0;
				released_q <= 1'b0;
				p_q        <= free_pg;
				ffree_q    <= ffree;
				b_q        <= (cmd_q == CMD_ALLOC && !size_bad) ? dec_bin : '0;
				if (cmd_q == CMD_ALLOC && size_bad) begin
					st_q <= ST_BAD_SIZE;
				end
				if (cmd_q == CMD_FREE && !used_q[free_pg]) begin
					st_q <= ST_BAD_FREE;
				end
			end
			S_A_HEAD: begin
				if (fresh_go) begin
					p_q       <= ffree_q[PAGE_W-1:0];
					created_q <= 1'b1;
					pos_q     <= fresh_pos[POS_W-1:0];
					calc_q    <= 1'b1;
					unl_q     <= 1'b0;
				end else if (head[PTR_W-1]) begin
					st_q <= ST_NO_PAGE;
				end else begin
					p_q <= head[PAGE_W-1:0];
				end
			end
			S_A_REC: begin
				pos_q  <= a_pos[POS_W-1:0];
				calc_q <= a_calc;
				unl_q  <= (a_pos == '0) && rec_rdata.on;
				pv_q   <= rec_rdata.prv;
				nx_q   <= rec_rdata.nxt;
			end
			S_A_OFF: off_q <= calc_q ? off_calc : stk_rdata;
			S_F_REC: begin
				b_q        <= f_bin;
				pv_q       <= rec_rdata.prv;
				nx_q       <= rec_rdata.nxt;
				released_q <= f_rel;
			end
			S_L1: nx_q <= head;
			default: begin
			end
		endcase
	end

	// handshakes and result
	assign in_ready          = state_q == S_IDLE;
	assign res_valid         = (state_q == S_DONE) && res_ready;
	assign res.status        = st_q;
	assign res.block_address = (cmd_q == CMD_ALLOC && st_q == ST_OK) ? {p_q, off_q} : '0;
	assign res.bin           = b_q;
	assign res.page_created  = created_q;
	assign res.page_released = released_q;

endmodule

`default_nettype wire

// ----- hdl/binned_slab_allocator_core.sv -----
// An allocate that empties its list goes on through the unlink states S_U1, S_U2
// and S_U3 before its result is registered; a plain one goes straight to S_DONE.
// Items: one at a time, each running the chain of dependent page-record, list-head
// and slot-stack accesses; the next is taken once the result is registered.
// Reset: all list heads empty and all pages free at once; no clearing pass.
// ----------------------------------------------------------------------------
// binned_slab_allocator_core
// Small-object allocator with 51 size classes over a 64-page arena.
// ----------------------------------------------------------------------------
`default_nettype none

module binned_slab_allocator_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       command,
	input  wire logic [15:0]                size,
	input  wire logic [21:0]                address,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [1:0]                      status,
	output logic [21:0]                     block_address,
	output logic [5:0]                      bin,
	output logic                            page_created,
	output logic                            page_released
);

	import bsa_pkg::*;

	rec_req_t          rec_req;
	lh_req_t           lh_req;
	stk_req_t          stk_req;
	logic [REC_W-1:0]  rec_raw;
	logic [PTR_W-1:0]  lh_rdata;
	logic [OFF_W-1:0]  stk_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	// sequencer
	bsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.size      (size),
		.address   (address),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.rec_req   (rec_req),
		.rec_rdata (prec_t'(rec_raw)),
		.lh_req    (lh_req),
		.lh_rdata  (lh_rdata),
		.stk_req   (stk_req),
		.stk_rdata (stk_rdata)
	);

	// page records
	bsa_ram #(.DW(REC_W), .DEPTH(NUM_PAGES), .AW(PAGE_W)) u_rec_ram (
		.clk   (clk),
		.re    (rec_req.re),
		.we    (rec_req.we),
		.addr  (rec_req.addr),
		.wmask (rec_req.mask),
		.wdata (rec_req.wdata),
		.rdata (rec_raw)
	);

	// list heads per class
	bsa_ram #(.DW(PTR_W), .DEPTH(NUM_BINS), .AW(BIN_W)) u_lh_ram (
		.clk   (clk),
		.re    (lh_req.re),
		.we    (lh_req.we),
		.addr  (lh_req.addr),
		.wmask ({PTR_W{1'b1}}),
		.wdata (lh_req.wdata),
		.rdata (lh_rdata)
	);

	// slot offset stacks
	bsa_ram #(.DW(OFF_W), .DEPTH(STK_DEPTH), .AW(STK_AW)) u_stk_ram (
		.clk   (clk),
		.re    (stk_req.re),
		.we    (stk_req.we),
		.addr  (stk_req.addr),
		.wmask ({OFF_W{1'b1}}),
		.wdata (stk_req.wdata),
		.rdata (stk_rdata)
	);

	// output register
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign block_address = out_q.block_address;
	assign bin           = out_q.bin;
	assign page_created  = out_q.page_created;
	assign page_released = out_q.page_released;

	// checks
	a_created_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && page_created |-> status == ST_OK && !page_released)
		else $error("page created on a failed or releasing item");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> block_address == '0)
		else $error("block address set on a failed item");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in work");

	a_released_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && page_released |-> status == ST_OK && block_address == '0)
		else $error("page released on an allocate or failed item");

endmodule

`default_nettype wire
